FILE: rtl/trace_averager_defines.svh
// Assertion macros shared by the trace averager modules.
// Depends on nothing; the using module must have clk_i and rst_ni in scope.
`ifndef TRACE_AVERAGER_DEFINES_SVH
`define TRACE_AVERAGER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TAVG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("trace_averager: check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TAVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("trace_averager: check failed");

`endif

FILE: rtl/tavg_pkg.sv
// Shared constants and types of the trace averager.
// Depends on nothing; used by tavg_seq, tavg_update and trace_averager.
package tavg_pkg;

  localparam int TRACE_DEPTH = 8192;
  localparam int COUNT_LIMIT = 512;
  localparam int COUNT_EXTRA = 10;
  localparam int COUNT_MAX   = COUNT_LIMIT + COUNT_EXTRA;

  localparam int SAMPLE_W = 8;
  localparam int ACC_W    = 16;
  localparam int SET_W    = 4;
  localparam int POS_W    = $clog2(TRACE_DEPTH);
  localparam int MEM_DEPTH = 2 * TRACE_DEPTH;
  localparam int ADDR_W   = $clog2(MEM_DEPTH);
  localparam int CNT_W    = $clog2(COUNT_MAX + 1);

  // One sample on its way from the sequencer to the update stage.
  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                warm;   // trace count still below the setting
    logic                first;  // first trace of the warm-up
    logic [SET_W-1:0]    shift;
  } req_t;

endpackage

FILE: rtl/tavg_seq.sv
// Input sequencer: setting register, per-channel position and trace counters.
// Depends on tavg_pkg and trace_averager_defines.svh.
`include "trace_averager_defines.svh"

module tavg_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [tavg_pkg::SET_W-1:0]    cfg_data_i,
  output logic                          cfg_ready_o,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          in_channel_i,
  input  logic [tavg_pkg::SAMPLE_W-1:0] in_sample_i,
  input  logic                          in_last_i,
  output tavg_pkg::req_t                req_o
);
  import tavg_pkg::*;

  logic [SET_W-1:0] setting_q;
  logic [POS_W-1:0] pos_q   [2];
  logic [CNT_W-1:0] count_q [2];
  logic [POS_W-1:0] cur_pos, pos_d;
  logic [CNT_W-1:0] cur_cnt, cnt_d;
  logic             accept, cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign accept      = in_valid_i && in_ready_i;

  assign cur_pos = pos_q[in_channel_i];
  assign cur_cnt = count_q[in_channel_i];

  always_comb begin
    req_o.addr   = in_channel_i ? ADDR_W'(TRACE_DEPTH) + ADDR_W'(cur_pos) : ADDR_W'(cur_pos);
    req_o.sample = in_sample_i;
    req_o.last   = in_last_i;
    req_o.warm   = cur_cnt < CNT_W'(setting_q);
    req_o.first  = cur_cnt == '0;
    req_o.shift  = setting_q;
  end

  always_comb begin
    if (in_last_i) begin
      pos_d = '0;
    end else if (cur_pos == POS_W'(TRACE_DEPTH - 1)) begin
      pos_d = '0;
    end else begin
      pos_d = cur_pos + POS_W'(1);
    end
    if (in_last_i && (cur_cnt < CNT_W'(COUNT_MAX))) begin
      cnt_d = cur_cnt + CNT_W'(1);
    end else begin
      cnt_d = cur_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setting_q  <= '0;
      pos_q[0]   <= '0;
      pos_q[1]   <= '0;
      count_q[0] <= '0;
      count_q[1] <= '0;
    end else begin
      if (accept) begin
        pos_q[in_channel_i] <= pos_d;
      end
      if (cfg_fire) begin
        setting_q  <= cfg_data_i;
        count_q[0] <= '0;
        count_q[1] <= '0;
      end else if (accept) begin
        count_q[in_channel_i] <= cnt_d;
      end
    end
  end

  `TAVG_ASSERT_NEXT(a_cfg_clears, cfg_fire, (count_q[0] == '0) && (count_q[1] == '0))
  `TAVG_ASSERT_NOW(a_cnt_bound0, 1'b1, count_q[0] <= CNT_W'(COUNT_MAX))
  `TAVG_ASSERT_NOW(a_cnt_bound1, 1'b1, count_q[1] <= CNT_W'(COUNT_MAX))
  `TAVG_ASSERT_NEXT(a_pos_restart, accept && in_last_i, pos_q[$past(in_channel_i)] == '0)

endmodule

FILE: rtl/tavg_update.sv
// Accumulator memory with read-modify-write update stage and output register.
// Depends on tavg_pkg and trace_averager_defines.svh.
`include "trace_averager_defines.svh"

module tavg_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  tavg_pkg::req_t                req_i,
  output logic                          req_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tavg_pkg::SAMPLE_W-1:0] out_sample_o,
  output logic                          out_averaged_o,
  output logic                          out_last_o
);
  import tavg_pkg::*;

  logic [ACC_W-1:0]    mem [MEM_DEPTH];
  logic [ACC_W-1:0]    rdata_q;
  logic [ADDR_W-1:0]   rd_addr;

  logic                s1_valid_q;
  req_t                s1_req_q;
  logic                s1_adv, hold;

  logic                fwd_q;
  logic [ACC_W-1:0]    fwd_data_q;

  logic [ACC_W-1:0]    acc_old, acc_new;
  logic [SAMPLE_W-1:0] result;
  logic                wr_en;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic                out_averaged_q;
  logic                out_last_q;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign hold        = s1_valid_q && !s1_adv;
  assign req_ready_o = !hold;
  assign wr_en       = s1_adv;

  // A stalled item keeps re-reading its own entry so its read data stays fresh.
  assign rd_addr = hold ? s1_req_q.addr : req_i.addr;

  // The write of the item ahead lands in the same cycle as this read; take it over.
  assign acc_old = fwd_q ? fwd_data_q : rdata_q;

  always_comb begin
    if (s1_req_q.warm) begin
      if (s1_req_q.first) begin
        acc_new = ACC_W'(s1_req_q.sample);
      end else begin
        acc_new = acc_old + ACC_W'(s1_req_q.sample);
      end
      result = s1_req_q.sample;
    end else begin
      acc_new = acc_old - (acc_old >> s1_req_q.shift) + ACC_W'(s1_req_q.sample);
      result  = SAMPLE_W'(acc_new >> s1_req_q.shift);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_req_q.addr] <= acc_new;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= acc_new;
    if (!hold) begin
      s1_req_q <= req_i;
    end
    if (s1_adv) begin
      out_sample_q   <= result;
      out_averaged_q <= !s1_req_q.warm;
      out_last_q     <= s1_req_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!hold) begin
        s1_valid_q <= req_valid_i;
      end
      fwd_q <= wr_en && (s1_req_q.addr == rd_addr);
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_sample_o   = out_sample_q;
  assign out_averaged_o = out_averaged_q;
  assign out_last_o     = out_last_q;

  `TAVG_ASSERT_NEXT(a_adv_loads_out, s1_adv, out_valid_q)
  `TAVG_ASSERT_NEXT(a_hold_keeps_addr, hold, $stable(s1_req_q.addr) && s1_valid_q)
  `TAVG_ASSERT_NOW(a_fwd_after_write, fwd_q, $past(wr_en))
  `TAVG_ASSERT_NEXT(a_avg_flag, s1_adv && !s1_req_q.warm, out_averaged_q)

endmodule

FILE: rtl/trace_averager.sv
// Top level of the two-channel point-by-point trace averager.
// Depends on tavg_pkg, tavg_seq, tavg_update and trace_averager_defines.svh.
//
// Usage: samples enter on the slave stream, one beat per sample. tdata holds
// the 8-bit sample, tuser the channel (0 or 1) and tlast marks the final
// sample of a trace. Every input beat gives exactly one output beat on the
// master stream: tdata holds the output sample, tuser is high when it came
// from the moving average (low during warm-up, when the raw sample passes
// through) and tlast repeats the end-of-trace mark.
// The configuration channel writes the 4-bit averaging setting n; a write also
// restarts the warm-up of both channels. Write it only while the block is idle.
// A beat passes the update stage register, then the output register.
// Throughput is one beat per clock while m_axis_tready is high: the
// accumulator memory is read in the cycle before its update and written in
// the update cycle, and a same-cycle write to the entry being read is
// forwarded to the next item. Reset clears the setting, positions and trace
// counters; the accumulator memory is not cleared and holds valid data only
// once the first trace of a channel has been stored. When the receiver stalls,
// the output register holds its beat, the item in the update stage waits and
// re-reads its entry, and s_axis_tready falls until the output is taken.
module trace_averager (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tavg_pkg::SET_W-1:0]    cfg_data_i,
  // Sample input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tavg_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [7:0] sample
  input  logic                          s_axis_tuser,   // [0] channel
  input  logic                          s_axis_tlast,
  // Result output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tavg_pkg::SAMPLE_W-1:0] m_axis_tdata,   // [7:0] out_sample
  output logic                          m_axis_tuser,   // [0] averaged
  output logic                          m_axis_tlast
);
  import tavg_pkg::*;

  req_t req;
  logic req_ready;

  tavg_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_ready_o  (cfg_ready_o),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (req_ready),
    .in_channel_i (s_axis_tuser),
    .in_sample_i  (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .req_o        (req)
  );

  tavg_update u_update (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid),
    .req_i          (req),
    .req_ready_o    (req_ready),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_sample_o   (m_axis_tdata),
    .out_averaged_o (m_axis_tuser),
    .out_last_o     (m_axis_tlast)
  );

  assign s_axis_tready = req_ready;

endmodule
